[hdl/onts_pkg.sv]
// ----------------------------------------------------------------------------
// onts_pkg
// Shared types, constants and helpers for the ordered name table.
// ----------------------------------------------------------------------------
`default_nettype none

package onts_pkg;

   localparam int DEPTH      = 63;
   localparam int NAME_BYTES = 24;
   localparam int NAME_W     = NAME_BYTES * 8;
   localparam int NUM_W      = 64;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int PLEN_W     = 5;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_FIND   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_MATCH = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_MISS  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // name byte 0 sits in bits 7:0
   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [NUM_W-1:0]  number;
   } entry_type;

   typedef struct packed {
      logic take_next;
      logic load_new;
   } cell_ctl_type;

   // clear every byte after the first zero byte; byte 23 is always cleared
   function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] w;
      logic              ended;
      w     = raw;
      ended = 1'b0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         if (k == NAME_BYTES - 1 || raw[8*k +: 8] == 8'd0) begin
            ended = 1'b1;
         end
         if (ended) begin
            w[8*k +: 8] = 8'd0;
         end
      end
      return w;
   endfunction

endpackage

`default_nettype wire

[hdl/ordered_name_table_prefix_search_unit.sv]
// Add and unknown commands: one result, registered in the cycle after start; busy stays low.
// Find and delete: busy while the table rotates once through the compare head,
// one entry per cycle, then through the closing state.
// Find matches come out in table order, at most one per cycle, then the last word.
// Reset clears the entry count and control; slot contents are not cleared.
// ----------------------------------------------------------------------------
// ordered_name_table_prefix_search_unit
// Ordered name/number table held in a ring of cells, with exact delete and
// prefix find.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_name_table_prefix_search_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_kind,
   input  wire  [63:0] req_key_bytes_lo,
   input  wire  [63:0] req_key_bytes_mid,
   input  wire  [63:0] req_key_bytes_hi,
   input  wire  [4:0]  req_prefix_len,
   input  wire  [63:0] req_entry_number,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_out_bytes_lo,
   output logic [63:0] rsp_out_bytes_mid,
   output logic [63:0] rsp_out_bytes_hi,
   output logic [63:0] rsp_out_number,
   output logic        rsp_last
);

   localparam int DEPTH  = onts_pkg::DEPTH;
   localparam int IDX_W  = onts_pkg::IDX_W;
   localparam int CNT_W  = onts_pkg::CNT_W;
   localparam int NAME_W = onts_pkg::NAME_W;

   onts_pkg::state_type        state_ff, state_in;
   logic [IDX_W-1:0]           step_ff, step_in;
   onts_pkg::kind_type         op_ff, op_in;
   logic [NAME_W-1:0]          key_ff, key_in;
   logic [onts_pkg::PLEN_W-1:0] plen_ff, plen_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   onts_pkg::status_type       rsp_status_ff, rsp_status_in;
   onts_pkg::entry_type        rsp_entry_ff, rsp_entry_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       rotate_en, shift_en, load_en;
   logic [NAME_W-1:0]          req_name_norm;
   onts_pkg::entry_type        new_entry;
   onts_pkg::entry_type        cell_q [DEPTH];
   logic                       prefix_hit, exact_hit;

   assign req_name_norm = onts_pkg::normalize({req_key_bytes_hi, req_key_bytes_mid,
                                               req_key_bytes_lo});
   assign new_entry.name   = req_name_norm;
   assign new_entry.number = req_entry_number;

   // ring of cells; cell 0 is the head seen by the compare unit
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      onts_pkg::cell_ctl_type ctl;
      assign ctl.take_next = rotate_en | (shift_en & (IDX_W'(i) >= hit_idx_ff));
      assign ctl.load_new  = load_en & (cnt_ff == CNT_W'(i));
      onts_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .next_entry (cell_q[(i + 1) % DEPTH]),
         .new_entry  (new_entry),
         .entry_q    (cell_q[i])
      );
   end

   onts_match u_match (
      .head_name  (cell_q[0].name),
      .key_name   (key_ff),
      .prefix_len (plen_ff),
      .prefix_hit (prefix_hit),
      .exact_hit  (exact_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= onts_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      plen_ff       <= plen_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      plen_in       = plen_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = onts_pkg::STATUS_DONE;
      rsp_entry_in  = '0;
      rsp_last_in   = 1'b0;
      rotate_en     = 1'b0;
      shift_en      = 1'b0;
      load_en       = 1'b0;

      unique case (state_ff)
         onts_pkg::ST_IDLE: begin
            if (start) begin
               op_in    = onts_pkg::kind_type'(req_kind);
               key_in   = req_name_norm;
               plen_in  = req_prefix_len;
               step_in  = '0;
               found_in = 1'b0;
               unique case (onts_pkg::kind_type'(req_kind)) inside
                  onts_pkg::KIND_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (cnt_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = onts_pkg::STATUS_FULL;
                     end else begin
                        load_en = 1'b1;
                        cnt_in  = cnt_ff + CNT_W'(1);
                     end
                  end
                  onts_pkg::KIND_DELETE, onts_pkg::KIND_FIND: begin
                     state_in = onts_pkg::ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
               endcase
            end
         end

         onts_pkg::ST_SCAN: begin
            // head holds entry number step_ff during this cycle
            rotate_en = 1'b1;
            if (CNT_W'(step_ff) < cnt_ff) begin
               if (op_ff == onts_pkg::KIND_FIND && prefix_hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = onts_pkg::STATUS_MATCH;
                  rsp_entry_in  = cell_q[0];
               end
               if (op_ff == onts_pkg::KIND_DELETE && exact_hit && !found_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = step_ff;
               end
            end
            if (step_ff == IDX_W'(DEPTH - 1)) begin
               state_in = onts_pkg::ST_FINISH;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end

         onts_pkg::ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = onts_pkg::ST_IDLE;
            if (op_ff == onts_pkg::KIND_DELETE) begin
               if (found_ff) begin
                  shift_en = 1'b1;
                  cnt_in   = cnt_ff - CNT_W'(1);
               end else begin
                  rsp_status_in = onts_pkg::STATUS_MISS;
               end
            end
         end

         default: begin
            state_in = onts_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != onts_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_bytes_lo  = rsp_entry_ff.name[63:0];
   assign rsp_out_bytes_mid = rsp_entry_ff.name[127:64];
   assign rsp_out_bytes_hi  = rsp_entry_ff.name[191:128];
   assign rsp_out_number    = rsp_entry_ff.number;
   assign rsp_last          = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   a_add_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == onts_pkg::KIND_ADD) |=> (rsp_valid && rsp_last))
      else $error("add did not answer in one cycle");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == onts_pkg::KIND_ADD && cnt_ff != CNT_W'(DEPTH))
      |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("add did not grow the table");

   a_finish_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == onts_pkg::ST_FINISH) |=> (rsp_valid && rsp_last && !busy))
      else $error("scan did not close with a last word");

   a_scan_no_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == onts_pkg::ST_SCAN) |=> !rsp_last)
      else $error("last word during scan");

endmodule

`default_nettype wire

[hdl/onts_cell.sv]
// ----------------------------------------------------------------------------
// onts_cell
// One table slot: holds an entry, takes its neighbor's entry or a new one.
// ----------------------------------------------------------------------------
`default_nettype none

module onts_cell (
   input  wire                         clock,
   input  wire onts_pkg::cell_ctl_type ctl,
   input  wire onts_pkg::entry_type    next_entry,
   input  wire onts_pkg::entry_type    new_entry,
   output onts_pkg::entry_type         entry_q
);

   onts_pkg::entry_type entry_ff;
   onts_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load_new) begin
         entry_in = new_entry;
      end else if (ctl.take_next) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

`default_nettype wire

[hdl/onts_match.sv]
// ----------------------------------------------------------------------------
// onts_match
// Compares the entry at the head of the chain with the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module onts_match (
   input  wire [onts_pkg::NAME_W-1:0] head_name,
   input  wire [onts_pkg::NAME_W-1:0] key_name,
   input  wire [onts_pkg::PLEN_W-1:0] prefix_len,
   output logic                       prefix_hit,
   output logic                       exact_hit
);

   always_comb begin
      prefix_hit = 1'b1;
      for (int k = 0; k < onts_pkg::NAME_BYTES; k++) begin
         // a length above the name size just compares all bytes
         if (onts_pkg::PLEN_W'(k) < prefix_len &&
             head_name[8*k +: 8] != key_name[8*k +: 8]) begin
            prefix_hit = 1'b0;
         end
      end
   end

   assign exact_hit = (head_name == key_name);

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered name table: a directed table of add,
// delete, find and unknown words, then weighted random traffic that fills
// the table, deletes and searches stored names. Every result word is checked
// against a model of the table kept here, in order.
// ----------------------------------------------------------------------------

module tb_top;

   typedef struct {
      onts_pkg::status_type              status;
      logic [onts_pkg::NAME_W-1:0]       name;
      logic [onts_pkg::NUM_W-1:0]        number;
      logic                              last;
   } rsp_word_type;

   typedef struct {
      onts_pkg::kind_type                kind;
      logic [onts_pkg::NAME_W-1:0]       key;
      logic [4:0]                        plen;
      logic [onts_pkg::NUM_W-1:0]        number;
      bit                                typed;
      onts_pkg::status_type              status;
   } plan_row_type;

   localparam logic [onts_pkg::NAME_W-1:0] JUNK_HI = {64'hC3A5_5A3C_0F1E_2D4B, 128'h0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_kind = 2'd0;
   logic [63:0] req_key_bytes_lo = '0;
   logic [63:0] req_key_bytes_mid = '0;
   logic [63:0] req_key_bytes_hi = '0;
   logic [4:0]  req_prefix_len = '0;
   logic [63:0] req_entry_number = '0;
   logic        busy;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_out_bytes_lo;
   logic [63:0] rsp_out_bytes_mid;
   logic [63:0] rsp_out_bytes_hi;
   logic [63:0] rsp_out_number;
   logic        rsp_last;

   ordered_name_table_prefix_search_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_key_bytes_lo  (req_key_bytes_lo),
      .req_key_bytes_mid (req_key_bytes_mid),
      .req_key_bytes_hi  (req_key_bytes_hi),
      .req_prefix_len    (req_prefix_len),
      .req_entry_number  (req_entry_number),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_bytes_lo  (rsp_out_bytes_lo),
      .rsp_out_bytes_mid (rsp_out_bytes_mid),
      .rsp_out_bytes_hi  (rsp_out_bytes_hi),
      .rsp_out_number    (rsp_out_number),
      .rsp_last          (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // table image and result words still owed by the block
   logic [onts_pkg::NAME_W-1:0] tbl_name [0:63];
   logic [onts_pkg::NUM_W-1:0]  tbl_num  [0:63];
   int                          tbl_count = 0;
   rsp_word_type                expected_words [$];
   plan_row_type                plan [$];
   int                          mismatch_count = 0;
   int                          send_idle_pct = 20;

   // index of the first zero byte, 23 if bytes 0..22 are all set
   function automatic int name_len(input logic [onts_pkg::NAME_W-1:0] w);
      for (int b = 0; b < onts_pkg::NAME_BYTES - 1; b++) begin
         if (w[8*b +: 8] == 8'h00) begin
            return b;
         end
      end
      return onts_pkg::NAME_BYTES - 1;
   endfunction

   function automatic logic [onts_pkg::NAME_W-1:0] clean_name(
         input logic [onts_pkg::NAME_W-1:0] raw);
      logic [onts_pkg::NAME_W-1:0] w;
      int                          len;
      w   = raw;
      len = name_len(raw);
      for (int b = len; b < onts_pkg::NAME_BYTES; b++) begin
         w[8*b +: 8] = 8'h00;
      end
      return w;
   endfunction

   function automatic logic [onts_pkg::NAME_W-1:0] str_name(input string s);
      logic [onts_pkg::NAME_W-1:0] w;
      w = '0;
      for (int b = 0; b < s.len() && b < onts_pkg::NAME_BYTES; b++) begin
         w[8*b +: 8] = s[b];
      end
      return w;
   endfunction

   function automatic logic [onts_pkg::NAME_W-1:0] rand_bits();
      return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   // short alphabet so prefixes collide often; garbage after the terminator
   function automatic logic [onts_pkg::NAME_W-1:0] fresh_raw();
      logic [onts_pkg::NAME_W-1:0] w;
      int                          len;
      w   = rand_bits();
      len = $urandom_range(0, onts_pkg::NAME_BYTES);
      for (int b = 0; b < len; b++) begin
         if ($urandom_range(3) == 0) begin
            w[8*b +: 8] = 8'($urandom_range(1, 255));
         end else begin
            w[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 2));
         end
      end
      if (len < onts_pkg::NAME_BYTES) begin
         w[8*len +: 8] = 8'h00;
      end
      return w;
   endfunction

   // a stored name dressed up with fresh garbage past its end
   function automatic logic [onts_pkg::NAME_W-1:0] raw_of(
         input logic [onts_pkg::NAME_W-1:0] name);
      logic [onts_pkg::NAME_W-1:0] w;
      int                          len;
      w   = rand_bits();
      len = name_len(name);
      for (int b = 0; b < len; b++) begin
         w[8*b +: 8] = name[8*b +: 8];
      end
      if (len < onts_pkg::NAME_BYTES - 1) begin
         w[8*len +: 8] = 8'h00;
      end
      return w;
   endfunction

   task automatic add_row(input onts_pkg::kind_type k,
                          input logic [onts_pkg::NAME_W-1:0] key,
                          input logic [4:0] plen, input logic [onts_pkg::NUM_W-1:0] num,
                          input bit typed, input onts_pkg::status_type st);
      plan.push_back('{k, key, plen, num, typed, st});
   endtask

   // applies one command to the table image; queues its result words if asked
   task automatic table_apply(input onts_pkg::kind_type k,
                              input logic [onts_pkg::NAME_W-1:0] raw,
                              input logic [4:0] plen,
                              input logic [onts_pkg::NUM_W-1:0] num,
                              input bit keep);
      logic [onts_pkg::NAME_W-1:0] key;
      int                          span;
      int                          hit_at;
      bit                          hit;
      rsp_word_type                w;
      key    = clean_name(raw);
      span   = (plen > onts_pkg::NAME_BYTES) ? onts_pkg::NAME_BYTES : int'(plen);
      hit_at = -1;
      w      = '{onts_pkg::STATUS_DONE, '0, '0, 1'b1};
      case (k)
         onts_pkg::KIND_ADD: begin
            if (tbl_count == onts_pkg::DEPTH) begin
               w.status = onts_pkg::STATUS_FULL;
            end else begin
               tbl_name[tbl_count] = key;
               tbl_num[tbl_count]  = num;
               tbl_count++;
            end
         end
         onts_pkg::KIND_DELETE: begin
            for (int i = 0; i < tbl_count && hit_at < 0; i++) begin
               if (tbl_name[i] == key) begin
                  hit_at = i;
               end
            end
            if (hit_at < 0) begin
               w.status = onts_pkg::STATUS_MISS;
            end else begin
               for (int j = hit_at; j + 1 < tbl_count; j++) begin
                  tbl_name[j] = tbl_name[j+1];
                  tbl_num[j]  = tbl_num[j+1];
               end
               tbl_count--;
            end
         end
         onts_pkg::KIND_FIND: begin
            for (int i = 0; i < tbl_count; i++) begin
               hit = 1'b1;
               for (int b = 0; b < span; b++) begin
                  if (tbl_name[i][8*b +: 8] != key[8*b +: 8]) begin
                     hit = 1'b0;
                  end
               end
               if (hit && keep) begin
                  expected_words.push_back('{onts_pkg::STATUS_MATCH, tbl_name[i],
                                             tbl_num[i], 1'b0});
               end
            end
         end
         default: begin
         end
      endcase
      if (keep) begin
         expected_words.push_back(w);
      end
   endtask

   // optional idle gap, then hold the word on the request ports until taken
   task automatic send_word(input onts_pkg::kind_type k,
                            input logic [onts_pkg::NAME_W-1:0] raw,
                            input logic [4:0] plen,
                            input logic [onts_pkg::NUM_W-1:0] num);
      int gap;
      gap = 0;
      if ($urandom_range(999) < send_idle_pct) begin
         gap = $urandom_range(1, 80);
      end else begin
         while ($urandom_range(99) < send_idle_pct && gap < 40) begin
            gap++;
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= k;
      req_key_bytes_lo  <= raw[63:0];
      req_key_bytes_mid <= raw[127:64];
      req_key_bytes_hi  <= raw[191:128];
      req_prefix_len    <= plen;
      req_entry_number  <= num;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: unexpected result word, status %0d last %b", $realtime,
                        rsp_status, rsp_last);
            end
         end else begin
            want = expected_words.pop_front();
            if (rsp_status !== want.status || rsp_last !== want.last ||
                {rsp_out_bytes_hi, rsp_out_bytes_mid, rsp_out_bytes_lo} !== want.name ||
                rsp_out_number !== want.number) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result mismatch", $realtime);
                  $display("   exp status %0d last %b name %h num %h", want.status,
                           want.last, want.name, want.number);
                  $display("   got status %0d last %b name %h num %h", rsp_status,
                           rsp_last, {rsp_out_bytes_hi, rsp_out_bytes_mid,
                           rsp_out_bytes_lo}, rsp_out_number);
               end
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("[ordered_name_table_prefix_search_unit] ERROR");
      $finish;
   end

   initial begin
      onts_pkg::kind_type          k;
      logic [onts_pkg::NAME_W-1:0] key;
      logic [4:0]                  plen;
      logic [onts_pkg::NUM_W-1:0]  num;
      int                          pick;
      int                          add_w;
      int                          taken;
      int                          phase_items [3];
      int                          phase_idle [3];
      bit                          full_seen;

      phase_items = '{45, 45, 40};
      phase_idle  = '{20, 70, 0};
      full_seen   = 1'b0;

      // empty table, extremes, normalization, duplicates, unknown kind
      add_row(onts_pkg::KIND_FIND,   '0, 5'd0, '0, 1, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_DELETE, str_name("ab"), 5'd0, '0, 1, onts_pkg::STATUS_MISS);
      add_row(onts_pkg::KIND_NONE,   '1, 5'd31, '1, 1, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_ADD,    '1, 5'd31, '1, 1, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_ADD,    '0, 5'd0, '0, 1, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_ADD,    str_name("abc") | JUNK_HI, 5'd0, 64'd1, 1,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_ADD,    str_name("abd"), 5'd0, 64'd2, 1,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_ADD,    str_name("ab"), 5'd0, 64'd3, 1,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_ADD,    str_name("abcdefghijklmnopqrstuvw"), 5'd0,
              64'h8000_0000_0000_0000, 1, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_FIND,   str_name("ab"), 5'd2, '0, 0, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_FIND,   '1, 5'd0, '0, 0, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_FIND,   '1, 5'd23, '0, 0, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_FIND,   str_name("abc"), 5'd24, '0, 0,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_FIND,   str_name("ab") | JUNK_HI, 5'd31, '0, 0,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_FIND,   str_name("abcdefghijklmnopqrstuvwx"), 5'd24, '0, 0,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_DELETE, str_name("abd") | JUNK_HI, 5'd0, '0, 1,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_DELETE, str_name("abd"), 5'd0, '0, 1,
              onts_pkg::STATUS_MISS);
      add_row(onts_pkg::KIND_ADD,    str_name("abc"), 5'd0, 64'd4, 1,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_DELETE, str_name("abc"), 5'd0, '0, 1,
              onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_FIND,   str_name("abc"), 5'd3, '0, 0, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_DELETE, '1, 5'd31, '1, 1, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_DELETE, '0, 5'd0, '0, 1, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_FIND,   str_name("a"), 5'd1, '0, 0, onts_pkg::STATUS_DONE);
      add_row(onts_pkg::KIND_NONE,   '0, 5'd0, '0, 1, onts_pkg::STATUS_DONE);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         send_word(plan[r].kind, plan[r].key, plan[r].plen, plan[r].number);
         table_apply(plan[r].kind, plan[r].key, plan[r].plen, plan[r].number,
                     !plan[r].typed);
         if (plan[r].typed) begin
            expected_words.push_back('{plan[r].status, '0, '0, 1'b1});
         end
      end

      // adds dominate until the table has filled once
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = phase_idle[ph];
         taken = 0;
         while (taken < phase_items[ph]) begin
            add_w = full_seen ? 45 : 70;
            pick  = $urandom_range(99);
            num   = {$urandom(), $urandom()};
            plen  = 5'($urandom_range(0, 31));
            if (pick < add_w) begin
               k   = onts_pkg::KIND_ADD;
               key = fresh_raw();
            end else if (pick < add_w + 15) begin
               k   = onts_pkg::KIND_DELETE;
               key = (tbl_count > 0 && $urandom_range(9) < 8) ?
                     raw_of(tbl_name[$urandom_range(0, tbl_count - 1)]) : fresh_raw();
            end else if (pick < 95) begin
               k   = onts_pkg::KIND_FIND;
               key = (tbl_count > 0 && $urandom_range(3) != 0) ?
                     raw_of(tbl_name[$urandom_range(0, tbl_count - 1)]) : fresh_raw();
               if ($urandom_range(9) < 7) begin
                  plen = 5'($urandom_range(0, name_len(clean_name(key)) + 1));
               end
            end else begin
               k   = onts_pkg::KIND_NONE;
               key = rand_bits();
            end
            send_word(k, key, plen, num);
            table_apply(k, key, plen, num, 1'b1);
            if (tbl_count == onts_pkg::DEPTH) begin
               full_seen = 1'b1;
            end
            if (k != onts_pkg::KIND_NONE) begin
               taken++;
            end
         end
      end

      start <= 1'b0;
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (80) @(posedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("[ordered_name_table_prefix_search_unit] OK");
      end else begin
         $display("[ordered_name_table_prefix_search_unit] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/onts_pkg.sv
hdl/onts_cell.sv
hdl/onts_match.sv
hdl/ordered_name_table_prefix_search_unit.sv
sim/tb_top.sv
